/* rtl/core/capture_period_averager_unit_defines.svh */
// Assertion macros shared by the capture period averager RTL.
// Depends on nothing; each macro expects clk and rst_n in scope where it is used.
`ifndef CAPTURE_PERIOD_AVERAGER_UNIT_DEFINES_SVH
`define CAPTURE_PERIOD_AVERAGER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cpa_pkg.sv */
// Package for the capture period averager: widths, codes, constants and state type.
// Depends on nothing; used by the divider and the top level.
package cpa_pkg;

  // Default number of periods averaged per report
  localparam int unsigned GROUP_SIZE_DEF = 10;

  // Field widths
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned Q4_W     = 36;
  localparam int unsigned FRAC_W   = 4;

  // Quotient bits resolved per divider cycle
  localparam int unsigned DIV_STEP = 4;

  // Input command codes
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  // Report kinds
  localparam logic KIND_AVG   = 1'b0;
  localparam logic KIND_STALL = 1'b1;

  // Stall report value and register reset
  localparam logic [PERIOD_W-1:0] STALL_PERIOD    = 32'd72000000;
  localparam logic [Q4_W-1:0]     STALL_PERIOD_Q4 = Q4_W'(STALL_PERIOD) << FRAC_W;
  localparam logic [CNT_W-1:0]    STALL_LIMIT_RST = 16'd200;
  localparam logic [CNT_W-1:0]    OVF_MAX         = 16'hFFFF;

  // Configuration address map: register index sits above the byte offset
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic        REG_STALL_LIMIT = 1'b0;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_EMIT
  } cpa_state_t;

endpackage

/* rtl/core/cpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

/* rtl/core/cpa_div.sv */
// Restoring divider for a narrow constant-sized divisor, DIV_STEP quotient bits per cycle.
// Depends on cpa_pkg (DIV_STEP).
module cpa_div #(
  parameter int unsigned N_W = 40,
  parameter int unsigned D_W = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           busy_o,
  output logic           done_o,
  output logic [N_W-1:0] quot_o
);
  import cpa_pkg::*;

  localparam int unsigned ITER  = (N_W + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned PAD_W = ITER * DIV_STEP;
  localparam int unsigned ITC_W = $clog2(ITER + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [ITC_W-1:0] cnt_r, cnt_nxt;
  logic [PAD_W-1:0] work_r, work_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   dsr_r, dsr_nxt;

  // DIV_STEP restoring steps: shift a dividend bit into the remainder, subtract if it fits
  always_comb begin
    logic [D_W:0]     trial;
    logic [D_W-1:0]   rem;
    logic [PAD_W-1:0] w;
    rem      = rem_r;
    w        = work_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial = {rem, w[PAD_W-1]};
      w     = {w[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        trial = trial - {1'b0, dsr_r};
        w[0]  = 1'b1;
      end
      rem = trial[D_W-1:0];
    end
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      work_nxt = PAD_W'(dividend_i);
      rem_nxt  = '0;
      dsr_nxt  = divisor_i;
    end else if (busy_r) begin
      work_nxt = w;
      rem_nxt  = rem;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == ITC_W'(ITER - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign busy_o = busy_r;
  assign done_o = done_r;
  assign quot_o = work_r[N_W-1:0];

endmodule

/* rtl/core/capture_period_averager_unit.sv */
// Capture period averager top level: sequencer, period store, running sum, config port.
// Depends on cpa_pkg, cpa_ram, cpa_div and capture_period_averager_unit_defines.svh.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_cmd, in_capture_count
//   out     | output    | out_valid/out_ready| out_report_kind, out_period_q4,
//           |           |                    | out_outlier_dropped
//   cfg     | input     | APB, pready high   | stall_limit at byte address 0
//
// Ticks and storing captures leave the sequencer in idle; a stall tick passes through the handoff
// state to hand off its beat. A reporting capture scans the store through the RAM read port
// (stopping early when an outlier turns up), runs the sum through the divider, waits for the
// divider's done and then hands off its beat.
// Reset clears control state and the running sum; the store needs no clearing pass.
// A finished beat waits in the output register; a later result waits in the handoff
// state until that register frees, and in_ready stays low meanwhile.
`include "capture_period_averager_unit_defines.svh"

module capture_period_averager_unit #(
  parameter int unsigned GROUP_SIZE = cpa_pkg::GROUP_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input beats
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [cpa_pkg::CNT_W-1:0]       in_capture_count,
  // result beats
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_report_kind,
  output logic [cpa_pkg::Q4_W-1:0]        out_period_q4,
  output logic                            out_outlier_dropped,
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cpa_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [cpa_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [cpa_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import cpa_pkg::*;

  localparam int unsigned SLOT_W = $clog2(GROUP_SIZE + 1);
  localparam int unsigned ADDR_W = $clog2(GROUP_SIZE);
  localparam int unsigned SUM_W  = PERIOD_W + $clog2(GROUP_SIZE);
  localparam int unsigned CMP_W  = SUM_W + 2;
  localparam int unsigned N_W    = SUM_W + FRAC_W;
  localparam int unsigned D_W    = SLOT_W;

  localparam logic [SLOT_W-1:0] GROUP_N  = SLOT_W'(GROUP_SIZE);
  localparam logic [D_W-1:0]    DIV_FULL = D_W'(GROUP_SIZE);
  localparam logic [D_W-1:0]    DIV_DROP = D_W'(GROUP_SIZE - 1);
  localparam logic [CMP_W-1:0]  MUL_2G   = CMP_W'(2 * GROUP_SIZE);

  cpa_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  stall_limit_r, stall_limit_nxt;
  logic [CNT_W-1:0]  ovf_r, ovf_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CMP_W-1:0]  three_s_r, three_s_nxt;
  logic [SLOT_W-1:0] scan_addr_r, scan_addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              kind_r, kind_nxt;
  logic              drop_r, drop_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [Q4_W-1:0]   out_period_r, out_period_nxt;
  logic              out_drop_r, out_drop_nxt;

  logic                in_fire;
  logic                cfg_wr;
  logic [CNT_W-1:0]    ovf_inc;
  logic                ram_wr_en;
  logic [PERIOD_W-1:0] ram_wr_data;
  logic [PERIOD_W-1:0] ram_rd_data;
  logic                hit;
  logic [SUM_W-1:0]    sum_sel;
  logic [D_W-1:0]      dsr_sel;
  logic                div_start;
  logic [N_W-1:0]      div_dividend;
  logic                div_busy;
  logic                div_done;
  logic [N_W-1:0]      div_quot;

  // Period store
  cpa_ram #(
    .WIDTH (PERIOD_W),
    .DEPTH (GROUP_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot_r[ADDR_W-1:0]),
    .wr_data (ram_wr_data),
    .rd_addr (scan_addr_r[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Rounded Q4 average
  cpa_div #(
    .N_W (N_W),
    .D_W (D_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (dsr_sel),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign ovf_inc  = (ovf_r == OVF_MAX) ? ovf_r : ovf_r + 1'b1;
  assign ram_wr_data = {ovf_r, in_capture_count};

  // Outlier test on the entry read last cycle: p * 2G > 3S
  assign hit     = rd_vld_r && ((CMP_W'(ram_rd_data) * MUL_2G) > three_s_r);
  assign sum_sel = hit ? (sum_r - SUM_W'(ram_rd_data)) : sum_r;
  assign dsr_sel = hit ? DIV_DROP : DIV_FULL;
  assign div_dividend = {sum_sel, FRAC_W'(0)} + N_W'(dsr_sel >> 1);

  // Configuration writes
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_STALL_LIMIT) ?
                      CFG_DATA_W'(stall_limit_r) : '0;

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt       = state_r;
    stall_limit_nxt = stall_limit_r;
    ovf_nxt         = ovf_r;
    slot_nxt        = slot_r;
    sum_nxt         = sum_r;
    three_s_nxt     = three_s_r;
    scan_addr_nxt   = scan_addr_r;
    rd_vld_nxt      = 1'b0;
    kind_nxt        = kind_r;
    drop_nxt        = drop_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_period_nxt  = out_period_r;
    out_drop_nxt    = out_drop_r;
    ram_wr_en       = 1'b0;
    div_start       = 1'b0;

    if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1:2] == REG_STALL_LIMIT)) begin
      stall_limit_nxt = cfg_pwdata[CNT_W-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_TICK) begin
            ovf_nxt = ovf_inc;
            if (ovf_inc > stall_limit_r) begin
              kind_nxt  = KIND_STALL;
              drop_nxt  = 1'b0;
              state_nxt = ST_EMIT;
            end
          end else begin
            ovf_nxt = '0;
            if (slot_r == GROUP_N) begin
              // store full: this capture reports the average
              slot_nxt      = '0;
              three_s_nxt   = (CMP_W'(sum_r) << 1) + CMP_W'(sum_r);
              scan_addr_nxt = '0;
              state_nxt     = ST_SCAN;
            end else begin
              ram_wr_en = 1'b1;
              slot_nxt  = slot_r + 1'b1;
              sum_nxt   = sum_r + SUM_W'(ram_wr_data);
            end
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, test the entry that comes back
        if (scan_addr_r != GROUP_N) begin
          scan_addr_nxt = scan_addr_r + 1'b1;
          rd_vld_nxt    = 1'b1;
        end
        if (hit || (rd_vld_r && (scan_addr_r == GROUP_N))) begin
          div_start = 1'b1;
          kind_nxt  = KIND_AVG;
          drop_nxt  = hit;
          sum_nxt   = '0;
          rd_vld_nxt = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = kind_r;
          out_period_nxt = (kind_r == KIND_STALL) ? STALL_PERIOD_Q4 : div_quot[Q4_W-1:0];
          out_drop_nxt   = drop_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      stall_limit_r <= STALL_LIMIT_RST;
      ovf_r         <= '0;
      slot_r        <= '0;
      sum_r         <= '0;
      scan_addr_r   <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      stall_limit_r <= stall_limit_nxt;
      ovf_r         <= ovf_nxt;
      slot_r        <= slot_nxt;
      sum_r         <= sum_nxt;
      scan_addr_r   <= scan_addr_nxt;
      rd_vld_r      <= rd_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    three_s_r    <= three_s_nxt;
    kind_r       <= kind_nxt;
    drop_r       <= drop_nxt;
    out_kind_r   <= out_kind_nxt;
    out_period_r <= out_period_nxt;
    out_drop_r   <= out_drop_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_report_kind     = out_kind_r;
  assign out_period_q4       = out_period_r;
  assign out_outlier_dropped = out_drop_r;

  // Checks
  `CPA_ASSERT_NOW(a_slot_range, 1'b1, slot_r <= GROUP_N, "slot count past group size")
  `CPA_ASSERT_NEXT(a_slot_step,
                   in_fire && (in_cmd == CMD_CAPTURE) && (slot_r != GROUP_N),
                   slot_r == $past(slot_r) + 1'b1, "storing capture did not advance slot")
  `CPA_ASSERT_NEXT(a_report_scan,
                   in_fire && (in_cmd == CMD_CAPTURE) && (slot_r == GROUP_N),
                   (state_r == ST_SCAN) && (slot_r == '0), "full store did not start a scan")
  `CPA_ASSERT_NOW(a_div_alive, state_r == ST_DIV, div_busy || div_done,
                  "waiting on an idle divider")
  `CPA_ASSERT_NOW(a_stall_clean, out_valid_r && (out_kind_r == KIND_STALL), !out_drop_r,
                  "stall beat flags a dropped outlier")

endmodule
